/* sv/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define AST_IMPL(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Consequence checked in the cycle after the antecedent.
`define AST_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/flspq_pkg.sv */
`default_nettype none
package flspq_pkg;

	// Width of the level field on both sides.
	localparam int LVL_W = 3;

	localparam logic [1:0] STAT_INSERTED = 2'd0;
	localparam logic [1:0] STAT_FULL     = 2'd1;
	localparam logic [1:0] STAT_REMOVED  = 2'd2;
	localparam logic [1:0] STAT_EMPTY    = 2'd3;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} ctrl_state_t;

endpackage
`default_nettype wire

/* sv/four_level_stable_priority_queue_core.sv */
// Flow: an accepted beat is latched along with its tag memory read, then S_EXEC loads the result
// register, held there under backpressure; a new beat is taken only once S_IDLE is back.
// The tag memory holds one circular FIFO per level; head, tail and count per level in flops.
// Reset: arst_n clears occupancy, per-level pointers/counts and handshake state;
// memory contents are not cleared and no clearing pass runs.
`default_nettype none
`include "assert_macros.svh"

module four_level_stable_priority_queue_core
	import flspq_pkg::*;
#(
	parameter int CAPACITY = 64,
	parameter int TAG_BITS = 16,
	parameter int LEVELS   = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	// [TAG_BITS-1:0] entry_tag, [TAG_BITS+2:TAG_BITS] priority_level, zero pad
	input  wire logic [((TAG_BITS+LVL_W+7)/8)*8-1:0] s_tdata,
	// [0] operation
	input  wire logic [0:0] s_tuser,
	output logic      m_tvalid,
	input  wire logic m_tready,
	// [TAG_BITS-1:0] out_tag, [TAG_BITS+2:TAG_BITS] out_level, zero pad
	output logic [((TAG_BITS+LVL_W+7)/8)*8-1:0] m_tdata,
	// [1:0] status
	output logic [1:0] m_tuser
);

	localparam int DW        = ((TAG_BITS + LVL_W + 7) / 8) * 8;
	localparam int LIW       = $clog2(LEVELS);
	localparam int PW        = $clog2(CAPACITY);
	localparam int OW        = $clog2(CAPACITY + 1);
	localparam int MEM_DEPTH = LEVELS * CAPACITY;
	localparam int AW        = $clog2(MEM_DEPTH);

	ctrl_state_t state_q, state_d;

	logic [TAG_BITS-1:0] mem [MEM_DEPTH];
	logic [TAG_BITS-1:0] rd_tag_q;

	logic [PW-1:0]  head_q [LEVELS];
	logic [PW-1:0]  tail_q [LEVELS];
	logic [OW-1:0]  cnt_q  [LEVELS];
	logic [OW-1:0]  occ_q;

	logic                op_q;
	logic [TAG_BITS-1:0] tag_q;
	logic [LIW-1:0]      lidx_q;

	logic                m_tvalid_q;
	logic [1:0]          out_status_q;
	logic [TAG_BITS-1:0] out_tag_q;
	logic [LVL_W-1:0]    out_lvl_q;

	logic                accept;
	logic                load;
	logic [LIW-1:0]      sel_idx;
	logic [LIW-1:0]      ins_idx;
	logic [LVL_W-1:0]    in_lvl;
	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	logic [1:0]          res_status;
	logic [TAG_BITS-1:0] res_tag;
	logic [LVL_W-1:0]    res_lvl;
	logic                is_full;
	logic                is_empty;

	assign in_lvl = s_tdata[TAG_BITS +: LVL_W];

	// Highest nonempty level; later index wins.
	always_comb begin
		sel_idx = '0;
		for (int i = 0; i < LEVELS; i++) begin
			if (cnt_q[i] != '0)
				sel_idx = LIW'(i);
		end
	end

	// Out-of-range levels saturate into 1..LEVELS.
	always_comb begin
		if (in_lvl == '0)
			ins_idx = '0;
		else if (32'(in_lvl) > LEVELS)
			ins_idx = LIW'(LEVELS - 1);
		else
			ins_idx = LIW'(in_lvl - LVL_W'(1));
	end

	assign is_full  = (occ_q == OW'(CAPACITY));
	assign is_empty = (occ_q == '0);

	assign accept  = s_tvalid && s_tready;
	assign load    = (state_q == S_EXEC) && (!m_tvalid_q || m_tready);
	assign rd_en   = accept && (s_tuser[0] == OP_REMOVE);
	assign rd_addr = AW'(sel_idx) * AW'(CAPACITY) + AW'(head_q[sel_idx]);
	assign wr_en   = load && (op_q == OP_INSERT) && !is_full;
	assign wr_addr = AW'(lidx_q) * AW'(CAPACITY) + AW'(tail_q[lidx_q]);

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= tag_q;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_tag_q <= mem[rd_addr];
	end

	always_comb begin
		res_tag = '0;
		res_lvl = '0;
		if (op_q == OP_INSERT) begin
			res_status = is_full ? STAT_FULL : STAT_INSERTED;
		end else if (is_empty) begin
			res_status = STAT_EMPTY;
		end else begin
			res_status = STAT_REMOVED;
			res_tag    = rd_tag_q;
			res_lvl    = LVL_W'(32'(lidx_q) + 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid)
					state_d = S_EXEC;
			end
			S_EXEC: begin
				if (load)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= s_tuser[0];
			tag_q  <= s_tdata[TAG_BITS-1:0];
			lidx_q <= (s_tuser[0] == OP_REMOVE) ? sel_idx : ins_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
		end else if (load) begin
			if (op_q == OP_INSERT && !is_full) begin
				occ_q          <= occ_q + OW'(1);
				cnt_q[lidx_q]  <= cnt_q[lidx_q] + OW'(1);
				tail_q[lidx_q] <= (tail_q[lidx_q] == PW'(CAPACITY - 1)) ? '0
					: tail_q[lidx_q] + PW'(1);
			end else if (op_q == OP_REMOVE && !is_empty) begin
				occ_q          <= occ_q - OW'(1);
				cnt_q[lidx_q]  <= cnt_q[lidx_q] - OW'(1);
				head_q[lidx_q] <= (head_q[lidx_q] == PW'(CAPACITY - 1)) ? '0
					: head_q[lidx_q] + PW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (load)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_status_q <= res_status;
			out_tag_q    <= res_tag;
			out_lvl_q    <= res_lvl;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = DW'({out_lvl_q, out_tag_q});

	`AST_IMPL(a_occ_bound, clk, arst_n, 1'b1, occ_q <= OW'(CAPACITY), "occupancy above capacity")
	`AST_NEXT(a_occ_hold, clk, arst_n, !load, $stable(occ_q), "occupancy moved without a result")
	`AST_NEXT(a_rm_dec, clk, arst_n, load && res_status == STAT_REMOVED, occ_q == $past(occ_q) - OW'(1), "remove did not shrink queue")
	`AST_IMPL(a_rm_lvl, clk, arst_n, m_tvalid && m_tuser == STAT_REMOVED, m_tdata[TAG_BITS +: LVL_W] != '0, "removed entry with zero level")

endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top
	import flspq_pkg::*;
;

	localparam int TAG_W     = 16;
	localparam int DATA_W    = ((TAG_W + LVL_W + 7) / 8) * 8;
	localparam int DEPTH     = 64;
	localparam int TOP_LEVEL = 4;
	localparam int STALL_LIMIT   = 2000;
	localparam int HOLDOFF_BEATS = 400;
	localparam int RANDOM_ITEMS  = 600;
	localparam int PHASE_ITEMS   = 60;

	typedef enum int {
		MIX_FILL,
		MIX_DRAIN,
		MIX_EVEN
	} traffic_mix_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [TAG_W-1:0] tag;
		logic [LVL_W-1:0] level;
	} outcome_t;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [LVL_W-1:0] level;
	} waiting_entry_t;

	// Shadow of the queue contents plus the outcomes still owed by the block.
	class queue_shadow;
		waiting_entry_t waiting[$];
		outcome_t owed[$];
		int errors;
		int responses;

		function int pending();
			return owed.size();
		endfunction

		function void note_request(logic op, logic [TAG_W-1:0] tag, logic [LVL_W-1:0] lvl);
			outcome_t o;
			waiting_entry_t e;
			int best;
			o = '0;
			if (op == OP_INSERT) begin
				if (waiting.size() >= DEPTH) begin
					o.status = STAT_FULL;
				end else begin
					o.status = STAT_INSERTED;
					e.tag = tag;
					// out-of-range severities saturate into 1..TOP_LEVEL
					if (lvl == 0)
						e.level = LVL_W'(1);
					else if (lvl > TOP_LEVEL)
						e.level = LVL_W'(TOP_LEVEL);
					else
						e.level = lvl;
					waiting.push_back(e);
				end
			end else if (waiting.size() == 0) begin
				o.status = STAT_EMPTY;
			end else begin
				// oldest entry of the highest level wins
				best = 0;
				for (int i = 1; i < waiting.size(); i++)
					if (waiting[i].level > waiting[best].level)
						best = i;
				o.status = STAT_REMOVED;
				o.tag = waiting[best].tag;
				o.level = waiting[best].level;
				waiting.delete(best);
			end
			owed.push_back(o);
		endfunction

		task report(string what, int got, int want);
			if (errors < 50)
				$display("MISMATCH beat %0d %s: got %0h expected %0h", responses, what, got,
					want);
			errors++;
		endtask

		task check_response(logic [1:0] st, logic [TAG_W-1:0] tag, logic [LVL_W-1:0] lvl);
			outcome_t e;
			responses++;
			if (owed.size() == 0) begin
				report("unexpected beat, status", st, 0);
				return;
			end
			e = owed.pop_front();
			if (st !== e.status)
				report("status", st, e.status);
			if (tag !== e.tag)
				report("out_tag", tag, e.tag);
			if (lvl !== e.level)
				report("out_level", lvl, e.level);
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [DATA_W-1:0] s_tdata = '0;
	logic [0:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [DATA_W-1:0] m_tdata;
	logic [1:0] m_tuser;

	// no random idling on either side while set
	bit steady = 1'b0;
	queue_shadow shadow = new();

	four_level_stable_priority_queue_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	task automatic send_request(logic op, logic [TAG_W-1:0] tag, logic [LVL_W-1:0] lvl);
		while (!steady && $urandom_range(99) < 30) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {{(DATA_W-TAG_W-LVL_W){1'b0}}, lvl, tag};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		shadow.note_request(op, tag, lvl);
	endtask

	task automatic send_insert(logic [TAG_W-1:0] tag, logic [LVL_W-1:0] lvl);
		send_request(OP_INSERT, tag, lvl);
	endtask

	task automatic send_remove();
		send_request(OP_REMOVE, TAG_W'($urandom), LVL_W'($urandom));
	endtask

	// result side
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			shadow.check_response(m_tuser, m_tdata[TAG_W-1:0], m_tdata[TAG_W+LVL_W-1:TAG_W]);
	end

	// receiver: random idling, one long hold-off while the sender keeps pushing
	initial begin
		bit held_once;
		held_once = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held_once && shadow.responses >= 100) begin
				held_once = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLDOFF_BEATS) @(posedge clk);
			end else begin
				m_tready <= steady || ($urandom_range(99) >= 30);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("four_level_stable_priority_queue_core verification failed");
				$finish;
			end
		end
	end

	initial begin
		traffic_mix_t mix;
		int insert_pct;
		logic [TAG_W-1:0] tag;
		logic [LVL_W-1:0] lvl;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty remove, tag extremes, every level, saturation, FIFO order
		send_remove();
		send_insert('0, 3'd1);
		send_insert('1, 3'd4);
		send_insert(16'h1234, 3'd2);
		send_insert(16'h8000, 3'd3);
		send_insert(16'h7fff, 3'd4);
		send_insert(16'h5555, 3'd0);
		send_insert(16'haaaa, 3'd7);
		send_insert(16'h0f0f, 3'd5);
		send_insert(16'hf0f0, 3'd6);
		send_insert(16'h0001, 3'd1);
		repeat (11) send_remove();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// fill, fill, mixed, drain, drain: hits both full and empty each round
			case ((n / PHASE_ITEMS) % 5)
				0, 1: begin
					mix = MIX_FILL;
				end
				2: begin
					mix = MIX_EVEN;
				end
				default: begin
					mix = MIX_DRAIN;
				end
			endcase
			insert_pct = (mix == MIX_FILL) ? 85 : (mix == MIX_DRAIN) ? 15 : 50;
			steady = (n >= 300 && n < 420);
			if ($urandom_range(99) < insert_pct) begin
				case ($urandom_range(15))
					0: tag = '0;
					1: tag = '1;
					default: tag = TAG_W'($urandom);
				endcase
				if ($urandom_range(19) == 0)
					lvl = ($urandom_range(3) == 0) ? 3'd0 : LVL_W'($urandom_range(5, 7));
				else
					lvl = LVL_W'($urandom_range(1, TOP_LEVEL));
				send_insert(tag, lvl);
			end else begin
				send_remove();
			end
		end
		s_tvalid <= 1'b0;
		steady = 1'b0;

		while (shadow.pending() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (shadow.errors == 0)
			$display("four_level_stable_priority_queue_core verification clean");
		else
			$display("four_level_stable_priority_queue_core verification failed");
		$finish;
	end

endmodule
